>>> sv/skdt_pkg.sv
// shared constants for the tanh kernel block
`default_nettype none

package skdt_pkg;

  localparam int ACC_BITS_DEFAULT     = 48;
  localparam int TANH_ENTRIES_DEFAULT = 1024;
  localparam int MID_DEPTH            = 4;

  localparam int GAMMA_W  = 16;
  localparam int OFFSET_W = 24;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 32;
  localparam int KV_W     = 16;

  localparam logic [GAMMA_W-1:0]  GAMMA_RESET  = 16'd4096;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'd0;

  localparam logic CFG_GAMMA  = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

endpackage

`default_nettype wire

>>> sv/skdt_front.sv
// front end: registered multiply and saturating accumulate of element pairs
`default_nettype none

module skdt_front
  import skdt_pkg::*;
#(
  parameter int ACC_BITS = ACC_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire logic signed [ELEM_W-1:0]   left_element,
  input  wire logic signed [ELEM_W-1:0]   right_element,
  input  wire logic                       last_pair,
  output logic                            done_push,
  output logic signed [ACC_BITS-1:0]      done_sum,
  output logic                            done_flag
);

  localparam int SUM_W = ACC_BITS + 1;

  logic                       p1_valid;
  logic                       p1_last;
  logic signed [PROD_W-1:0]   p1_prod;
  logic signed [ACC_BITS-1:0] dot_sum;
  logic                       saturation_seen;

  logic signed [SUM_W-1:0]    sum_wide;
  logic signed [ACC_BITS-1:0] sum_next;
  logic                       ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= take;
    end
    p1_prod <= left_element * right_element;
    p1_last <= last_pair;
  end

  always_comb begin
    sum_wide = SUM_W'(dot_sum) + SUM_W'(p1_prod);
    ovf      = sum_wide[SUM_W-1] != sum_wide[SUM_W-2];
    if (ovf && !sum_wide[SUM_W-1]) begin
      sum_next = {1'b0, {(ACC_BITS-1){1'b1}}};
    end else if (ovf) begin
      sum_next = {1'b1, {(ACC_BITS-1){1'b0}}};
    end else begin
      sum_next = sum_wide[ACC_BITS-1:0];
    end
  end

  assign done_push = p1_valid && p1_last;
  assign done_sum  = sum_next;
  assign done_flag = saturation_seen || ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum         <= '0;
      saturation_seen <= 1'b0;
    end else if (p1_valid) begin
      if (p1_last) begin
        dot_sum         <= '0;
        saturation_seen <= 1'b0;
      end else begin
        dot_sum         <= sum_next;
        saturation_seen <= saturation_seen || ovf;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/skdt_queue.sv
// short queue of finished sums between front and back
`default_nettype none

module skdt_queue
  import skdt_pkg::*;
#(
  parameter int DATA_W = ACC_BITS_DEFAULT + 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   rd_valid,
  output logic                   nearly_full
);

  localparam int PTR_W = $clog2(MID_DEPTH);
  localparam int CNT_W = $clog2(MID_DEPTH + 1);

  logic [DATA_W-1:0] slots [MID_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign rd_data     = slots[rd_ptr];
  assign rd_valid    = count != '0;
  assign nearly_full = count >= CNT_W'(MID_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/skdt_back.sv
// back end: scaling, offset, tanh table lookup with interpolation, result register
`default_nettype none

module skdt_back
  import skdt_pkg::*;
#(
  parameter int ACC_BITS           = ACC_BITS_DEFAULT,
  parameter int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic signed [GAMMA_W-1:0]   gamma_scale,
  input  wire logic signed [OFFSET_W-1:0]  offset_term,
  input  wire logic                        q_valid,
  input  wire logic signed [ACC_BITS-1:0]  q_sum,
  input  wire logic                        q_flag,
  output logic                             q_pop,
  input  wire logic                        pop,
  output logic                             empty,
  output logic signed [KV_W-1:0]           kernel_value,
  output logic                             saturated
);

  localparam int AW    = $clog2(TANH_TABLE_ENTRIES + 1);
  localparam int POS_W = 19 + AW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MLO  = 4'd1;
  localparam logic [3:0] S_MHI  = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_OFF  = 4'd4;
  localparam logic [3:0] S_POS  = 4'd5;
  localparam logic [3:0] S_ROM  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic signed [63:0] SUM_CLAMP = 64'sd70368744177664;
  localparam logic signed [44:0] Z_LIMIT   = 45'sd524288;
  localparam logic [63:0]        ONE_Q32   = 64'h1_0000_0000;
  localparam logic [63:0]        TANH_STEP = (64'd16 << 32) / 64'(TANH_TABLE_ENTRIES);

  typedef logic [15:0] rom_t [0:TANH_TABLE_ENTRIES];

  // shift and subtract quotient, only evaluated while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] val;
    t    = TANH_STEP;
    term = ONE_Q32;
    r    = ONE_Q32;
    e    = ONE_Q32;
    for (int n = 1; n <= 8; n++) begin
      term = div_u64((term * t) >> 32, 64'(n));
      if (n[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k <= TANH_TABLE_ENTRIES; k++) begin
      if (k > 0) begin
        e = (e * r + (64'd1 << 31)) >> 32;
      end
      num = ONE_Q32 - e;
      den = ONE_Q32 + e;
      val = div_u64(num * 64'd65536 + den, 64'd2 * den);
      if (val > 64'd32767) begin
        val = 64'd32767;
      end
      tab[k] = val[15:0];
    end
    return tab;
  endfunction

  localparam rom_t TANH_ROM = build_rom();

  logic [3:0]          state;
  logic signed [47:0]  s_q;
  logic                flag_q;
  logic signed [40:0]  p_lo;
  logic signed [39:0]  p_hi;
  logic signed [43:0]  zr;
  logic                neg_q;
  logic                big_q;
  logic [19:0]         a_q;
  logic [POS_W-1:0]    pos_q;
  logic [15:0]         lo_q;
  logic [15:0]         hi_q;
  logic [18:0]         f_q;
  logic [15:0]         frac_q;
  logic                out_valid;

  logic signed [63:0]  head64;
  logic signed [63:0]  head_clamped;
  logic signed [24:0]  mul_b;
  logic signed [40:0]  mul_p;
  logic signed [63:0]  prod64;
  logic signed [44:0]  zo;
  logic signed [44:0]  zc;
  logic                z_sat;
  logic [44:0]         z_abs;
  logic [AW-1:0]       idx;
  logic [35:0]         interp;
  logic [16:0]         mag_sum;
  logic [15:0]         mag;
  logic                out_free;

  assign out_free = !out_valid || pop;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign empty    = !out_valid;

  always_comb begin
    head64 = 64'(q_sum);
    if (head64 > SUM_CLAMP) begin
      head_clamped = SUM_CLAMP;
    end else if (head64 < -SUM_CLAMP) begin
      head_clamped = -SUM_CLAMP;
    end else begin
      head_clamped = head64;
    end
  end

  // one shared multiplier for both halves of the clamped sum
  assign mul_b  = (state == S_MLO) ? $signed({1'b0, s_q[23:0]}) : $signed({s_q[47], s_q[47:24]});
  assign mul_p  = gamma_scale * mul_b;
  assign prod64 = (64'(p_hi) <<< 24) + 64'(p_lo) + 64'sd524288;

  always_comb begin
    zo    = 45'(zr) + 45'(offset_term);
    z_sat = 1'b0;
    if (zo > Z_LIMIT) begin
      zc    = Z_LIMIT;
      z_sat = 1'b1;
    end else if (zo < -Z_LIMIT) begin
      zc    = -Z_LIMIT;
      z_sat = 1'b1;
    end else begin
      zc = zo;
    end
    z_abs = zc[44] ? 45'(-zc) : 45'(zc);
  end

  assign idx     = big_q ? '0 : pos_q[POS_W-1:19];
  assign interp  = 36'(hi_q - lo_q) * 36'(f_q) + 36'd262144;
  assign mag_sum = 17'(lo_q) + 17'(frac_q);

  always_comb begin
    if (big_q || mag_sum > 17'd32767) begin
      mag = 16'd32767;
    end else begin
      mag = mag_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        s_q    <= head_clamped[47:0];
        flag_q <= q_flag;
      end
      S_MLO: begin
        p_lo <= mul_p;
      end
      S_MHI: begin
        p_hi <= mul_p[39:0];
      end
      S_SUM: begin
        zr <= 44'(prod64 >>> 20);
      end
      S_OFF: begin
        neg_q  <= zc[44];
        a_q    <= z_abs[19:0];
        big_q  <= z_abs[19];
        flag_q <= flag_q || z_sat;
      end
      S_POS: begin
        pos_q <= POS_W'(a_q) * POS_W'(TANH_TABLE_ENTRIES);
      end
      S_ROM: begin
        lo_q <= TANH_ROM[idx];
        hi_q <= TANH_ROM[AW'(idx + 1'b1)];
        f_q  <= pos_q[18:0];
      end
      S_INT: begin
        frac_q <= interp[34:19];
      end
      default: begin
      end
    endcase
    if (state == S_OUT && out_free) begin
      kernel_value <= neg_q ? -$signed(mag) : $signed(mag);
      saturated    <= flag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE:  state <= q_valid ? S_MLO : S_IDLE;
        S_MLO:   state <= S_MHI;
        S_MHI:   state <= S_SUM;
        S_SUM:   state <= S_OFF;
        S_OFF:   state <= S_POS;
        S_POS:   state <= S_ROM;
        S_ROM:   state <= S_INT;
        S_INT:   state <= S_OUT;
        S_OUT:   state <= out_free ? S_IDLE : S_OUT;
        default: state <= S_IDLE;
      endcase
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sigmoid_kernel_dot_tanh_unit.sv
// top level of the tanh kernel block: config registers, front, queue and back
//
// Element pairs enter through push/full at up to one pair per clock: the front
// end multiplies in one stage and adds into the saturating accumulator in the
// next. Each pair marked last hands its finished sum to a four-entry queue, and
// the back end turns one queued sum at a time into a result (scale on one
// shared 16x25 multiplier over two passes, add the offset, then a two-port
// read of the tanh table and an interpolation step). Vectors no shorter than
// the back end's state sequence stream at full rate while results are popped;
// shorter ones are paced by the back end; full rises with at most one entry free.
// Results wait in an output register until popped while the next is worked on.
// Configuration writes are taken every clock (cfg_ready is always high) and
// should only be issued while the block is idle.
`default_nettype none

module sigmoid_kernel_dot_tanh_unit
  import skdt_pkg::*;
#(
  parameter int ACC_BITS           = ACC_BITS_DEFAULT,
  parameter int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [ELEM_W-1:0]  left_element,
  input  wire logic signed [ELEM_W-1:0]  right_element,
  input  wire logic                      last_pair,
  output logic                           empty,
  input  wire logic                      pop,
  output logic signed [KV_W-1:0]         kernel_value,
  output logic                           saturated,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [OFFSET_W-1:0]       cfg_data
);

  logic signed [GAMMA_W-1:0]  gamma_scale;
  logic signed [OFFSET_W-1:0] offset_term;

  logic                       take;
  logic                       done_push;
  logic signed [ACC_BITS-1:0] done_sum;
  logic                       done_flag;
  logic [ACC_BITS:0]          q_rd_data;
  logic                       q_valid;
  logic                       q_pop;
  logic                       q_nearly_full;

  assign cfg_ready = 1'b1;
  assign full      = q_nearly_full;
  assign take      = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_scale <= GAMMA_RESET;
      offset_term <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAMMA:  gamma_scale <= cfg_data[GAMMA_W-1:0];
        CFG_OFFSET: offset_term <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  skdt_front #(
    .ACC_BITS (ACC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .left_element  (left_element),
    .right_element (right_element),
    .last_pair     (last_pair),
    .done_push     (done_push),
    .done_sum      (done_sum),
    .done_flag     (done_flag)
  );

  skdt_queue #(
    .DATA_W (ACC_BITS + 1)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (done_push),
    .wr_data     ({done_flag, done_sum}),
    .rd_en       (q_pop),
    .rd_data     (q_rd_data),
    .rd_valid    (q_valid),
    .nearly_full (q_nearly_full)
  );

  skdt_back #(
    .ACC_BITS           (ACC_BITS),
    .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .gamma_scale  (gamma_scale),
    .offset_term  (offset_term),
    .q_valid      (q_valid),
    .q_sum        ($signed(q_rd_data[ACC_BITS-1:0])),
    .q_flag       (q_rd_data[ACC_BITS]),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kernel_value (kernel_value),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire
